[design/lcs_pkg.sv]
package lcs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	// Request codes
	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 3'd0,
		FN_DELETE = 3'd1,
		FN_DEQUEUE = 3'd2,
		FN_POP = 3'd3,
		FN_FIND = 3'd4
	} func_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN = 1'b1
	} state_t;

	// Control handed from the sequencer to the cell ring
	typedef struct packed {
		logic run;
		logic tail_cut;
		logic [DATA_W-1:0] fb;
	} ring_ctl_t;

endpackage

[design/lcs_cell.sv]
module lcs_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        sel_fb,
	input  logic [lcs_pkg::DATA_W-1:0]  d_nbr,
	input  logic [lcs_pkg::DATA_W-1:0]  d_fb,
	output logic [lcs_pkg::DATA_W-1:0]  q
);

	logic [lcs_pkg::DATA_W-1:0] data_q;

	// One slot: load from the upper neighbor or from the feedback line
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= sel_fb ? d_fb : d_nbr;
		end
	end

	assign q = data_q;

endmodule

[design/lcs_chain.sv]
module lcs_chain #(
	parameter int CAPACITY = lcs_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  lcs_pkg::ring_ctl_t          ctl,
	output logic [lcs_pkg::DATA_W-1:0]  head
);

	logic [lcs_pkg::DATA_W-1:0] q [CAPACITY];

	// Ring of slots shifting toward slot 0; the head re-enters at the top.
	// Once an element is dropped the ring closes one slot early, at the
	// second-to-last cell, which squeezes the gap out by the end of the pass.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [lcs_pkg::DATA_W-1:0] nbr;
		logic sel;

		if (i == CAPACITY - 1) begin : g_top
			assign nbr = ctl.fb;
			assign sel = 1'b1;
		end else if (i == CAPACITY - 2) begin : g_cut
			assign nbr = q[i+1];
			assign sel = ctl.tail_cut;
		end else begin : g_mid
			assign nbr = q[i+1];
			assign sel = 1'b0;
		end

		lcs_cell u_cell (
			.clk    (clk),
			.en     (ctl.run),
			.sel_fb (sel),
			.d_nbr  (nbr),
			.d_fb   (ctl.fb),
			.q      (q[i])
		);
	end

	assign head = q[0];

endmodule

[design/lcs_ctrl.sv]
module lcs_ctrl #(
	parameter int CAPACITY = lcs_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lcs_pkg::FUNC_W-1:0]   func,
	input  logic [lcs_pkg::DATA_W-1:0]   value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lcs_pkg::STAT_W-1:0]   status,
	output logic [lcs_pkg::DATA_W-1:0]   data,
	output logic [lcs_pkg::INDEX_W-1:0]  index,
	output logic [lcs_pkg::COUNT_W-1:0]  count,
	input  logic [lcs_pkg::DATA_W-1:0]   head,
	output lcs_pkg::ring_ctl_t           ctl
);

	localparam int CW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > lcs_pkg::INDEX_W) ? CW : lcs_pkg::INDEX_W;
	localparam int NW = (FW > lcs_pkg::COUNT_W) ? FW : lcs_pkg::COUNT_W;
	localparam logic [CW-1:0] LAST = CW'(CAPACITY - 1);
	localparam logic [FW-1:0] FULL_CNT = FW'(CAPACITY);

	lcs_pkg::state_t state_q, state_d;
	lcs_pkg::func_t func_q;
	logic [lcs_pkg::DATA_W-1:0] value_q;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] fill_q, fill_d;
	logic found_q, cut_q;
	logic [lcs_pkg::DATA_W-1:0] data_acc_q;
	logic [CW-1:0] idx_acc_q;
	logic out_valid_q;
	logic [lcs_pkg::STAT_W-1:0] status_q;
	logic [lcs_pkg::DATA_W-1:0] data_q;
	logic [lcs_pkg::INDEX_W-1:0] index_q;
	logic [lcs_pkg::COUNT_W-1:0] count_q;

	logic accept, last, slot_free, run, finish;
	logic [FW-1:0] pos;
	logic in_list, nonempty, full, match;
	logic hit, take, drop, wr_now, ok;
	logic [lcs_pkg::STAT_W-1:0] status_d;
	logic [IW-1:0] idx_wide;
	logic [NW-1:0] cnt_wide;

	assign accept = in_valid && in_ready;
	assign last = (cnt_q == LAST);
	assign slot_free = !out_valid_q || out_ready;
	assign run = (state_q == lcs_pkg::S_RUN) && (!last || slot_free);
	assign finish = run && last;

	// Per-step look at the element passing the head cell
	assign pos = FW'(cnt_q);
	assign in_list = (pos < fill_q);
	assign nonempty = (fill_q != '0);
	assign full = (fill_q == FULL_CNT);
	assign match = in_list && !found_q && (head == value_q);

	always_comb begin
		hit = 1'b0;
		take = 1'b0;
		drop = 1'b0;
		wr_now = 1'b0;
		unique case (func_q)
			lcs_pkg::FN_APPEND: begin
				wr_now = (pos == fill_q);
			end
			lcs_pkg::FN_DELETE: begin
				hit = match;
				drop = match;
			end
			lcs_pkg::FN_DEQUEUE: begin
				take = nonempty && (cnt_q == '0);
				drop = take;
			end
			lcs_pkg::FN_POP: begin
				take = nonempty && (pos == fill_q - FW'(1));
			end
			lcs_pkg::FN_FIND: begin
				hit = match;
			end
			default: begin
			end
		endcase
	end

	assign ctl.run = run;
	assign ctl.tail_cut = cut_q;
	assign ctl.fb = wr_now ? value_q : head;

	// Outcome at the end of the pass
	always_comb begin
		if (func_q == lcs_pkg::FN_APPEND) begin
			ok = !full;
		end else begin
			ok = found_q || hit || take;
		end
		if (ok) begin
			status_d = lcs_pkg::STAT_OK;
		end else if (func_q == lcs_pkg::FN_APPEND) begin
			status_d = lcs_pkg::STAT_FULL;
		end else begin
			status_d = lcs_pkg::STAT_EMPTY;
		end
		fill_d = fill_q;
		if (ok) begin
			priority case (func_q)
				lcs_pkg::FN_APPEND: fill_d = fill_q + FW'(1);
				lcs_pkg::FN_DELETE, lcs_pkg::FN_DEQUEUE, lcs_pkg::FN_POP:
					fill_d = fill_q - FW'(1);
				default: fill_d = fill_q;
			endcase
		end
		idx_wide = IW'(hit ? cnt_q : idx_acc_q);
		cnt_wide = NW'(fill_d);
	end

	// State machine
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcs_pkg::S_IDLE: begin
				if (accept) begin
					state_d = lcs_pkg::S_RUN;
				end
			end
			lcs_pkg::S_RUN: begin
				if (finish) begin
					state_d = lcs_pkg::S_IDLE;
				end
			end
			default: state_d = lcs_pkg::S_IDLE;
		endcase
	end

	assign in_ready = (state_q == lcs_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			found_q <= 1'b0;
			cut_q <= 1'b0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= '0;
				found_q <= 1'b0;
				cut_q <= 1'b0;
			end else if (run) begin
				cnt_q <= cnt_q + CW'(1);
				if (hit || take) begin
					found_q <= 1'b1;
				end
				if (drop) begin
					cut_q <= 1'b1;
				end
			end
			if (finish) begin
				fill_q <= fill_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, accumulator and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= lcs_pkg::func_t'(func);
			value_q <= value;
			data_acc_q <= '0;
			idx_acc_q <= '0;
		end else if (run) begin
			if (take) begin
				data_acc_q <= head;
			end
			if (hit) begin
				idx_acc_q <= cnt_q;
			end
		end
		if (finish) begin
			status_q <= status_d;
			data_q <= take ? head : data_acc_q;
			index_q <= idx_wide[lcs_pkg::INDEX_W-1:0];
			count_q <= cnt_wide[lcs_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign data = data_q;
	assign index = index_q;
	assign count = count_q;

endmodule

[design/compacting_list_store.sv]
// Every request makes one full pass of the slot ring, one slot per cycle while the
// pass is not stalled; a pending result only stalls the final step of the pass.
// A new item is taken only once the previous pass has finished; the next item is
// taken while a result waits.
// Reset (arst_n low): element count, sequencer and output valid clear at once;
// the slot cells are not reset and need no clearing pass.
module compacting_list_store #(
	parameter int CAPACITY = lcs_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lcs_pkg::FUNC_W-1:0]   func,
	input  logic [lcs_pkg::DATA_W-1:0]   value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lcs_pkg::STAT_W-1:0]   status,
	output logic [lcs_pkg::DATA_W-1:0]   data,
	output logic [lcs_pkg::INDEX_W-1:0]  index,
	output logic [lcs_pkg::COUNT_W-1:0]  count
);

	lcs_pkg::ring_ctl_t ctl;
	logic [lcs_pkg::DATA_W-1:0] head;

	lcs_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.data      (data),
		.index     (index),
		.count     (count),
		.head      (head),
		.ctl       (ctl)
	);

	lcs_chain #(
		.CAPACITY (CAPACITY)
	) u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

endmodule
